[sv/bscm_pkg.sv]
// ----------------------------------------------------------------------------
// bscm_pkg - shared types and constants of the bank switching cartridge mapper
// Word layouts of the bus access and result channels, the access and source
// codes, the register indexes and the address decode codes.
// ----------------------------------------------------------------------------
package bscm_pkg;

	// Access codes
	localparam logic [1:0] OP_PRG_READ  = 2'd0;
	localparam logic [1:0] OP_PRG_WRITE = 2'd1;
	localparam logic [1:0] OP_CHR_READ  = 2'd2;
	localparam logic [1:0] OP_CHR_WRITE = 2'd3;

	// Source codes of a result word
	localparam logic [2:0] SRC_NONE      = 3'd0;
	localparam logic [2:0] SRC_PRG_ROM   = 3'd1;
	localparam logic [2:0] SRC_CHR_ROM   = 3'd2;
	localparam logic [2:0] SRC_PRG_RAM   = 3'd3;
	localparam logic [2:0] SRC_NAMETABLE = 3'd4;

	// Configuration register indexes
	localparam logic [1:0] CFG_PRG_BANKS = 2'd0;
	localparam logic [1:0] CFG_CHR_SIZE  = 2'd1;
	localparam logic [1:0] CFG_FOUR_NT   = 2'd2;

	localparam logic [6:0] PRG_BANKS_RESET = 7'd32;
	localparam logic [8:0] CHR_SIZE_RESET  = 9'd256;

	// Mirroring codes
	localparam logic [1:0] MIRROR_VERTICAL = 2'd0;
	localparam logic [1:0] MIRROR_FOUR_NT  = 2'd2;

	// 8 KB regions, decoded from address bits 15:13
	localparam logic [2:0] REGION_CHR_ROM  = 3'b000;
	localparam logic [2:0] REGION_WORK_RAM = 3'b011;
	localparam logic [2:0] REGION_BANK     = 3'b100;
	localparam logic [2:0] REGION_MIRROR   = 3'b101;
	localparam logic [2:0] REGION_IRQ      = 3'b110;
	localparam logic [2:0] REGION_IRQ_EN   = 3'b111;

	// 4 KB page of the nametables, address bits 15:12
	localparam logic [3:0] NAMETABLE_PAGE = 4'h2;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] address;
		logic [7:0]  write_data;
	} bscm_req_t;

	typedef struct packed {
		logic [2:0]  source;
		logic [18:0] rom_address;
		logic [7:0]  read_data;
		logic [1:0]  mirroring;
		logic        mirroring_changed;
		logic        irq_active;
		logic        irq_raised;
		logic [7:0]  irq_reload_value;
	} bscm_rsp_t;

	// Result of the register unit: everything but the RAM byte
	typedef struct packed {
		logic [2:0]  source;
		logic [18:0] rom_address;
		logic [1:0]  mirroring;
		logic        mirroring_changed;
		logic        irq_active;
		logic        irq_raised;
		logic [7:0]  irq_reload_value;
	} bscm_map_t;

endpackage

[sv/bscm_ram.sv]
// ----------------------------------------------------------------------------
// bscm_ram - generic single port RAM with registered read
// One access per cycle; read data holds until the next read.
// ----------------------------------------------------------------------------
module bscm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

[sv/bscm_regs.sv]
// ----------------------------------------------------------------------------
// bscm_regs - mapper register file and address translation
// Holds the bank, mode, mirroring and IRQ registers and the slot tables, and
// translates PRG and CHR reads to ROM byte addresses.
// ----------------------------------------------------------------------------
module bscm_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  bscm_pkg::bscm_req_t req,
	input  logic                cfg_write_en,
	input  logic [1:0]          cfg_index,
	input  logic [8:0]          cfg_data,
	output bscm_pkg::bscm_map_t map
);
	import bscm_pkg::*;

	// Power-on CHR base of a slot: slots 0 and 3 take the last 2 KB pair
	function automatic logic [17:0] power_on_chr(input logic [8:0] banks, input int slot);
		logic [8:0] bank;
		bank = (slot == 0 || slot == 3) ? banks - 9'd2 : banks - 9'd1;
		return {bank[7:0], 10'b0};
	endfunction

	function automatic logic [5:0] power_on_prg(input logic [6:0] banks, input int slot);
		logic [6:0] bank;
		bank = slot[0] ? banks - 7'd1 : banks - 7'd2;
		return bank[5:0];
	endfunction

	logic [6:0]  cfg_prg_q;
	logic [8:0]  cfg_chr_q;
	logic        cfg_four_q;
	logic [7:0]  bank_q [8];
	logic [2:0]  target_q;
	logic        swap_q;
	logic        invert_q;
	logic [17:0] chr_base_q [8];
	logic [5:0]  prg_bank_q [4];
	logic [1:0]  mirror_q;
	logic [7:0]  latch_q;
	logic        flag_q;
	logic        enable_q;
	logic        touched_q;

	logic [2:0]  region;
	logic        odd;
	logic [7:0]  wv;
	logic        prg_wr, sel_wr, data_wr, mir_wr, latch_wr, reload_wr, en_wr;
	logic [1:0]  mirror_nxt;
	logic [7:0]  latch_nxt;
	logic        flag_nxt, enable_nxt;
	logic [7:0]  bank_nxt [8];
	logic [17:0] pair_base [4];
	logic [17:0] one_base [4];
	logic [17:0] chr_new [8];
	logic [5:0]  prg_new [4];
	logic [5:0]  fixed_bank, last_bank;
	logic [6:0]  cfg_prg_nxt;
	logic [8:0]  cfg_chr_nxt;
	logic        po_load;

	assign region = req.address[15:13];
	assign odd    = req.address[0];
	assign wv     = req.write_data;

	// Register write decode
	always_comb begin
		prg_wr    = accept && (req.op == OP_PRG_WRITE);
		sel_wr    = prg_wr && (region == REGION_BANK) && !odd;
		data_wr   = prg_wr && (region == REGION_BANK) && odd;
		mir_wr    = prg_wr && (region == REGION_MIRROR) && !odd;
		latch_wr  = prg_wr && (region == REGION_IRQ) && !odd;
		reload_wr = prg_wr && (region == REGION_IRQ) && odd;
		en_wr     = prg_wr && (region == REGION_IRQ_EN);
	end

	always_comb begin
		mirror_nxt = mirror_q;
		if (mir_wr) begin
			mirror_nxt = cfg_four_q ? MIRROR_FOUR_NT : {1'b0, wv[0]};
		end
		latch_nxt  = latch_wr ? wv : latch_q;
		flag_nxt   = flag_q | reload_wr;
		enable_nxt = en_wr ? odd : enable_q;
	end

	// Slot recompute from the bank values as they stand after this write
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			bank_nxt[i] = (data_wr && target_q == 3'(i)) ? wv : bank_q[i];
		end
		pair_base[0] = {bank_nxt[0][7:1], 1'b0, 10'b0};
		pair_base[1] = {bank_nxt[0][7:1], 1'b1, 10'b0};
		pair_base[2] = {bank_nxt[1][7:1], 1'b0, 10'b0};
		pair_base[3] = {bank_nxt[1][7:1], 1'b1, 10'b0};
		for (int i = 0; i < 4; i++) begin
			one_base[i] = {bank_nxt[2 + i], 10'b0};
		end
		for (int i = 0; i < 4; i++) begin
			chr_new[i]     = invert_q ? one_base[i] : pair_base[i];
			chr_new[4 + i] = invert_q ? pair_base[i] : one_base[i];
		end
		fixed_bank = power_on_prg(cfg_prg_q, 0);
		last_bank  = power_on_prg(cfg_prg_q, 1);
		prg_new[0] = swap_q ? fixed_bank : bank_nxt[6][5:0];
		prg_new[1] = bank_nxt[7][5:0];
		prg_new[2] = swap_q ? bank_nxt[6][5:0] : fixed_bank;
		prg_new[3] = last_bank;
	end

	// Size writes before any bank data write reload the power-on slots
	always_comb begin
		cfg_prg_nxt = cfg_prg_q;
		cfg_chr_nxt = cfg_chr_q;
		po_load     = 1'b0;
		if (cfg_write_en) begin
			if (cfg_index == CFG_PRG_BANKS) begin
				cfg_prg_nxt = cfg_data[6:0];
				po_load     = !touched_q;
			end else if (cfg_index == CFG_CHR_SIZE) begin
				cfg_chr_nxt = cfg_data;
				po_load     = !touched_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_prg_q  <= PRG_BANKS_RESET;
			cfg_chr_q  <= CHR_SIZE_RESET;
			cfg_four_q <= 1'b0;
			target_q   <= 3'd0;
			swap_q     <= 1'b0;
			invert_q   <= 1'b0;
			mirror_q   <= MIRROR_VERTICAL;
			latch_q    <= 8'd0;
			flag_q     <= 1'b0;
			enable_q   <= 1'b0;
			touched_q  <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				bank_q[i]     <= 8'd0;
				chr_base_q[i] <= power_on_chr(CHR_SIZE_RESET, i);
			end
			for (int i = 0; i < 4; i++) begin
				prg_bank_q[i] <= power_on_prg(PRG_BANKS_RESET, i);
			end
		end else begin
			cfg_prg_q <= cfg_prg_nxt;
			cfg_chr_q <= cfg_chr_nxt;
			if (cfg_write_en && cfg_index == CFG_FOUR_NT) begin
				cfg_four_q <= cfg_data[0];
			end
			if (sel_wr) begin
				target_q <= wv[2:0];
				swap_q   <= wv[6];
				invert_q <= wv[7];
			end
			mirror_q <= mirror_nxt;
			latch_q  <= latch_nxt;
			flag_q   <= flag_nxt;
			enable_q <= enable_nxt;
			if (data_wr) begin
				touched_q <= 1'b1;
				for (int i = 0; i < 8; i++) begin
					bank_q[i]     <= bank_nxt[i];
					chr_base_q[i] <= chr_new[i];
				end
				for (int i = 0; i < 4; i++) begin
					prg_bank_q[i] <= prg_new[i];
				end
			end else if (po_load) begin
				for (int i = 0; i < 8; i++) begin
					chr_base_q[i] <= power_on_chr(cfg_chr_nxt, i);
				end
				for (int i = 0; i < 4; i++) begin
					prg_bank_q[i] <= power_on_prg(cfg_prg_nxt, i);
				end
			end
		end
	end

	// Translation; reads leave the registers alone, so current slots apply
	always_comb begin
		map.source      = SRC_NONE;
		map.rom_address = 19'd0;
		unique case (req.op)
			OP_PRG_READ: begin
				if (region == REGION_WORK_RAM) begin
					map.source = SRC_PRG_RAM;
				end else if (req.address[15]) begin
					map.source      = SRC_PRG_ROM;
					map.rom_address = {prg_bank_q[req.address[14:13]], req.address[12:0]};
				end
			end
			OP_CHR_READ: begin
				if (region == REGION_CHR_ROM) begin
					map.source      = SRC_CHR_ROM;
					map.rom_address = {1'b0, chr_base_q[req.address[12:10]]}
						+ {9'd0, req.address[9:0]};
				end else if (req.address[15:12] == NAMETABLE_PAGE) begin
					map.source = SRC_NAMETABLE;
				end
			end
			default: begin
			end
		endcase
		map.mirroring         = mirror_nxt;
		map.mirroring_changed = mir_wr;
		map.irq_active        = enable_nxt;
		map.irq_raised        = flag_nxt;
		map.irq_reload_value  = latch_nxt;
	end

endmodule

[sv/bank_switching_cartridge_mapper.sv]
// ----------------------------------------------------------------------------
// bank_switching_cartridge_mapper - banked cartridge mapper with internal RAM
// An access is registered in stage 1 with its RAM read, then in stage 2.
// Throughput: one access per cycle unless the output stalls; the single
// read port of each internal RAM and the slot registers are each touched
// once per access.
// Reset clears all mapper registers to their power-on values at once; the
// PRG RAM and nametable RAM contents stay undefined until written.
// ----------------------------------------------------------------------------
module bank_switching_cartridge_mapper #(
	parameter int WORK_RAM_BYTES      = 8192,
	parameter int NAMETABLE_RAM_BYTES = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  bscm_pkg::bscm_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output bscm_pkg::bscm_rsp_t rsp,
	input  logic                cfg_write_en,
	input  logic [1:0]          cfg_index,
	input  logic [8:0]          cfg_data
);
	import bscm_pkg::*;

	localparam int WORK_AW = $clog2(WORK_RAM_BYTES);
	localparam int NT_AW   = $clog2(NAMETABLE_RAM_BYTES);

	// Pipeline: stage 1 waits for the RAM read, stage 2 is the output word.
	logic      accept;
	logic      s1_advance;
	logic      s1_valid_s1;
	bscm_map_t map;
	bscm_map_t map_s1;
	logic      rsp_valid_s2;
	bscm_rsp_t rsp_s2;

	logic       work_en, work_we;
	logic       nt_en, nt_we;
	logic [7:0] work_rdata, nt_rdata;
	logic [7:0] ram_byte;

	// Stage 1 moves on whenever the output word is empty or being taken.
	// A new word enters when stage 1 is empty or moving on, so the RAM read
	// data stays put while stage 1 is held.
	assign s1_advance = !rsp_valid_s2 || !rsp_stall;
	assign req_stall  = s1_valid_s1 && !s1_advance;
	assign accept     = req_valid && !req_stall;

	bscm_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.req          (req),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.map          (map)
	);

	// PRG RAM at 0x6000-0x7FFF, reached by PRG reads and writes.
	always_comb begin
		work_en = accept && !req.op[1] && (req.address[15:13] == REGION_WORK_RAM);
		work_we = (req.op == OP_PRG_WRITE);
		// Nametable RAM at 0x2000-0x2FFF, reached by CHR reads and writes.
		nt_en   = accept && req.op[1] && (req.address[15:12] == NAMETABLE_PAGE);
		nt_we   = (req.op == OP_CHR_WRITE);
	end

	bscm_ram #(
		.WIDTH (8),
		.DEPTH (WORK_RAM_BYTES)
	) u_work_ram (
		.clk   (clk),
		.en    (work_en),
		.we    (work_we),
		.addr  (req.address[WORK_AW-1:0]),
		.wdata (req.write_data),
		.rdata (work_rdata)
	);

	bscm_ram #(
		.WIDTH (8),
		.DEPTH (NAMETABLE_RAM_BYTES)
	) u_nametable_ram (
		.clk   (clk),
		.en    (nt_en),
		.we    (nt_we),
		.addr  (req.address[NT_AW-1:0]),
		.wdata (req.write_data),
		.rdata (nt_rdata)
	);

	// Stage 1: hold the translated word while the RAM read completes; fill
	// whenever the input is open, even with the output word held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			s1_valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			map_s1 <= map;
		end
	end

	// Pick the RAM byte by source; writes and ROM reads carry zero
	always_comb begin
		case (map_s1.source)
			SRC_PRG_RAM:   ram_byte = work_rdata;
			SRC_NAMETABLE: ram_byte = nt_rdata;
			default:       ram_byte = 8'd0;
		endcase
	end

	// Stage 2: output word, advance when empty or taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (s1_advance) begin
			rsp_valid_s2 <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance && s1_valid_s1) begin
			rsp_s2.source            <= map_s1.source;
			rsp_s2.rom_address       <= map_s1.rom_address;
			rsp_s2.read_data         <= ram_byte;
			rsp_s2.mirroring         <= map_s1.mirroring;
			rsp_s2.mirroring_changed <= map_s1.mirroring_changed;
			rsp_s2.irq_active        <= map_s1.irq_active;
			rsp_s2.irq_raised        <= map_s1.irq_raised;
			rsp_s2.irq_reload_value  <= map_s1.irq_reload_value;
		end
	end

	assign rsp_valid = rsp_valid_s2;
	assign rsp       = rsp_s2;

	// The input is held back only by a word waiting in stage 1.
	a_stall_needs_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> s1_valid_s1)
		else $error("input held back with stage 1 empty");

	// An accepted word always lands in stage 1.
	a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid_s1)
		else $error("accepted word lost before stage 1");

	// A word without a source carries neither an address nor a byte.
	a_none_is_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.source == SRC_NONE) |->
			(rsp.rom_address == 19'd0 && rsp.read_data == 8'd0))
		else $error("result with no source carries data");

	// Only the RAM sources carry a byte.
	a_byte_from_ram : assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.read_data != 8'd0) |->
			(rsp.source == SRC_PRG_RAM || rsp.source == SRC_NAMETABLE))
		else $error("read byte on a non-RAM source");

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench - self-checking bench of the bank switching cartridge mapper
// Drives CPU and PPU bus accesses through the valid/stall channels, predicts
// every result word from an independent model of the mapper registers, the
// bank slots and both internal RAMs, and compares each word field by field.
// Runs a directed opening and then random traffic under several register
// settings and sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bscm_pkg::*;

	localparam int WORK_RAM_BYTES  = 8192;
	localparam int NAMETABLE_BYTES = 4096;
	localparam int PHASES          = 8;
	localparam int PHASE_WORDS     = 138;
	localparam logic [1:0] MIRROR_HORIZONTAL = 2'd1;

	// Prediction of the mapper: register state, slot tables and RAM images,
	// plus the queue of result words still owed by the block.
	class mapper_scoreboard;
		bit [6:0]  prg_banks;
		bit [8:0]  chr_size;
		bit        four_nt;
		bit [7:0]  work_ram [WORK_RAM_BYTES];
		bit [7:0]  nametable [NAMETABLE_BYTES];
		bit [7:0]  bank_data [8];
		bit [2:0]  bank_target;
		bit        prg_swap;
		bit        chr_invert;
		bit        banks_written;
		bit [17:0] chr_base [8];
		bit [5:0]  prg_bank [4];
		bit [1:0]  mirror;
		bit [7:0]  reload_value;
		bit        irq_raised;
		bit        irq_enable;
		bscm_rsp_t pending_results [$];
		int        errors;
		int        checked;
		int        by_source [8];

		function new();
			prg_banks = PRG_BANKS_RESET;
			chr_size  = CHR_SIZE_RESET;
			mirror    = MIRROR_VERTICAL;
			power_on_slots();
		endfunction

		function void power_on_slots();
			bit [17:0] last;
			bit [17:0] pair;
			last = {8'(chr_size - 9'd1), 10'd0};
			pair = {8'(chr_size - 9'd2), 10'd0};
			foreach (chr_base[i])
				chr_base[i] = last;
			chr_base[0] = pair;
			chr_base[3] = pair;
			prg_bank[0] = 6'(prg_banks - 7'd2);
			prg_bank[1] = 6'(prg_banks - 7'd1);
			prg_bank[2] = prg_bank[0];
			prg_bank[3] = prg_bank[1];
		endfunction

		function void remap_slots();
			bit [17:0] pair [4];
			bit [17:0] single [4];
			bit [5:0]  fixed;
			int        lo;
			int        hi;
			fixed   = 6'(prg_banks - 7'd2);
			pair[0] = {bank_data[0][7:1], 1'b0, 10'd0};
			pair[1] = {bank_data[0][7:1], 1'b1, 10'd0};
			pair[2] = {bank_data[1][7:1], 1'b0, 10'd0};
			pair[3] = {bank_data[1][7:1], 1'b1, 10'd0};
			for (int i = 0; i < 4; i++)
				single[i] = {bank_data[2 + i], 10'd0};
			lo = chr_invert ? 4 : 0;
			hi = chr_invert ? 0 : 4;
			for (int i = 0; i < 4; i++) begin
				chr_base[lo + i] = pair[i];
				chr_base[hi + i] = single[i];
			end
			prg_bank[0] = prg_swap ? fixed : bank_data[6][5:0];
			prg_bank[2] = prg_swap ? bank_data[6][5:0] : fixed;
			prg_bank[1] = bank_data[7][5:0];
			prg_bank[3] = 6'(prg_banks - 7'd1);
		endfunction

		function void set_config(logic [1:0] index, logic [8:0] value);
			case (index)
				CFG_PRG_BANKS: prg_banks = value[6:0];
				CFG_CHR_SIZE:  chr_size = value;
				CFG_FOUR_NT:   four_nt = value[0];
				default: ;
			endcase
			// size changes only reach the slots until the first bank data write
			if (index != CFG_FOUR_NT && !banks_written)
				power_on_slots();
		endfunction

		// CPU write at 0x6000 and up; returns whether it hit the mirroring register
		function bit cpu_write(bit [15:0] a, bit [7:0] v);
			cpu_write = 1'b0;
			case (a[15:13])
				REGION_WORK_RAM: work_ram[a[12:0]] = v;
				REGION_BANK: begin
					if (!a[0]) begin
						bank_target = v[2:0];
						prg_swap    = v[6];
						chr_invert  = v[7];
					end else begin
						bank_data[bank_target] = v;
						banks_written = 1'b1;
						remap_slots();
					end
				end
				REGION_MIRROR: begin
					// odd addresses are the RAM protect register: ignored
					if (!a[0]) begin
						if (four_nt)
							mirror = MIRROR_FOUR_NT;
						else
							mirror = v[0] ? MIRROR_HORIZONTAL : MIRROR_VERTICAL;
						cpu_write = 1'b1;
					end
				end
				REGION_IRQ: begin
					if (!a[0])
						reload_value = v;
					else
						irq_raised = 1'b1;
				end
				REGION_IRQ_EN: irq_enable = a[0];
				default: ;
			endcase
		endfunction

		function void note_access(bscm_req_t w);
			bscm_rsp_t r;
			r = '0;
			case (w.op)
				OP_PRG_READ: begin
					if (w.address[15:13] == REGION_WORK_RAM) begin
						r.source    = SRC_PRG_RAM;
						r.read_data = work_ram[w.address[12:0]];
					end else if (w.address[15]) begin
						r.source      = SRC_PRG_ROM;
						r.rom_address = {prg_bank[w.address[14:13]], w.address[12:0]};
					end
				end
				OP_PRG_WRITE: r.mirroring_changed = cpu_write(w.address, w.write_data);
				OP_CHR_READ: begin
					if (w.address[15:13] == REGION_CHR_ROM) begin
						r.source      = SRC_CHR_ROM;
						r.rom_address = 19'(chr_base[w.address[12:10]]) + 19'(w.address[9:0]);
					end else if (w.address[15:12] == NAMETABLE_PAGE) begin
						r.source    = SRC_NAMETABLE;
						r.read_data = nametable[w.address[11:0]];
					end
				end
				default: begin
					if (w.address[15:12] == NAMETABLE_PAGE)
						nametable[w.address[11:0]] = w.write_data;
				end
			endcase
			r.mirroring        = mirror;
			r.irq_active       = irq_enable;
			r.irq_raised       = irq_raised;
			r.irq_reload_value = reload_value;
			pending_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				if (errors < 10)
					$display("MISMATCH result %0d field %s: expected %0h, got %0h",
						checked, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(bscm_rsp_t got);
			bscm_rsp_t want;
			if (pending_results.size() == 0) begin
				if (errors < 10)
					$display("MISMATCH result word %h arrived with nothing expected", got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("source", 32'(want.source), 32'(got.source));
			compare_field("rom_address", 32'(want.rom_address), 32'(got.rom_address));
			compare_field("read_data", 32'(want.read_data), 32'(got.read_data));
			compare_field("mirroring", 32'(want.mirroring), 32'(got.mirroring));
			compare_field("mirroring_changed", 32'(want.mirroring_changed),
				32'(got.mirroring_changed));
			compare_field("irq_active", 32'(want.irq_active), 32'(got.irq_active));
			compare_field("irq_raised", 32'(want.irq_raised), 32'(got.irq_raised));
			compare_field("irq_reload_value", 32'(want.irq_reload_value),
				32'(got.irq_reload_value));
			by_source[want.source]++;
			checked++;
		endfunction

		function int outstanding();
			return pending_results.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	bscm_req_t  req = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	bscm_rsp_t  rsp;
	logic       cfg_write_en = 1'b0;
	logic [1:0] cfg_index = CFG_PRG_BANKS;
	logic [8:0] cfg_data = '0;

	mapper_scoreboard sb = new();

	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;

	// Generator bookkeeping: which RAM bytes have been written, so that a read
	// only ever lands on a byte with a known value.
	bit        wram_written [WORK_RAM_BYTES];
	bit        nt_written [NAMETABLE_BYTES];
	int        wram_list [$];
	int        nt_list [$];
	bscm_req_t queued_words [$];

	int phase_prg [PHASES] = '{32, 64, 2, 64, 2, -1, -1, 64};
	int phase_chr [PHASES] = '{256, 256, 8, 8, 256, -1, -1, 256};
	int phase_fs  [PHASES] = '{0, 0, 1, 0, 1, -1, -1, 1};
	int phase_tx  [PHASES] = '{0, 66, 0, 8, 0, 66, 0, 8};
	int phase_rx  [PHASES] = '{0, 0, 66, 8, 0, 0, 66, 8};

	bank_switching_cartridge_mapper dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// Receiver: check every accepted result word, then pick next cycle's stall.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_result(rsp);
		rsp_stall <= arst_n && ($urandom_range(99) < rx_stall_pct);
	end

	function automatic bscm_req_t make_word(logic [1:0] op, logic [15:0] a, logic [7:0] v);
		bscm_req_t w;
		w.op         = op;
		w.address    = a;
		w.write_data = v;
		return w;
	endfunction

	// Turn a read of a never-written RAM byte into a write, and record the
	// bytes that writes fill in.
	function automatic bscm_req_t track_ram(bscm_req_t w);
		bscm_req_t t;
		t = w;
		if (t.op == OP_PRG_READ && t.address[15:13] == REGION_WORK_RAM
				&& !wram_written[t.address[12:0]])
			t.op = OP_PRG_WRITE;
		if (t.op == OP_CHR_READ && t.address[15:12] == NAMETABLE_PAGE
				&& !nt_written[t.address[11:0]])
			t.op = OP_CHR_WRITE;
		if (t.op == OP_PRG_WRITE && t.address[15:13] == REGION_WORK_RAM
				&& !wram_written[t.address[12:0]]) begin
			wram_written[t.address[12:0]] = 1'b1;
			wram_list.push_back(int'(t.address[12:0]));
		end
		if (t.op == OP_CHR_WRITE && t.address[15:12] == NAMETABLE_PAGE
				&& !nt_written[t.address[11:0]]) begin
			nt_written[t.address[11:0]] = 1'b1;
			nt_list.push_back(int'(t.address[11:0]));
		end
		return t;
	endfunction

	// Mostly well-formed traffic: ROM fetches, select/data pairs, register and
	// RAM writes, RAM read-backs; the last tenth is unrestricted noise.
	function automatic bscm_req_t next_access();
		bscm_req_t w;
		bscm_req_t data_word;
		int        pick;
		if (queued_words.size() != 0)
			return track_ram(queued_words.pop_front());
		w    = make_word(OP_PRG_READ, 16'($urandom), 8'($urandom));
		pick = $urandom_range(99);
		if (pick < 20) begin
			w.address[15] = 1'b1;
		end else if (pick < 40) begin
			w.op = OP_CHR_READ;
			w.address[15:13] = REGION_CHR_ROM;
		end else if (pick < 55) begin
			// bank select now, bank data next
			w.op = OP_PRG_WRITE;
			w.address[15:13] = REGION_BANK;
			w.address[0] = 1'b0;
			data_word = make_word(OP_PRG_WRITE, 16'($urandom), 8'($urandom));
			data_word.address[15:13] = REGION_BANK;
			data_word.address[0] = 1'b1;
			queued_words.push_back(data_word);
		end else if (pick < 63) begin
			w.op = OP_PRG_WRITE;
			w.address[15:13] = 3'($urandom_range(REGION_IRQ_EN, REGION_MIRROR));
		end else if (pick < 71) begin
			w.op = OP_PRG_WRITE;
			w.address[15:13] = REGION_WORK_RAM;
		end else if (pick < 77) begin
			w.op = OP_CHR_WRITE;
			w.address[15:12] = NAMETABLE_PAGE;
		end else if (pick < 84) begin
			w.address[15:13] = REGION_WORK_RAM;
			if (wram_list.size() != 0)
				w.address[12:0] = 13'(wram_list[$urandom_range(wram_list.size() - 1)]);
		end else if (pick < 90) begin
			w.op = OP_CHR_READ;
			w.address[15:12] = NAMETABLE_PAGE;
			if (nt_list.size() != 0)
				w.address[11:0] = 12'(nt_list[$urandom_range(nt_list.size() - 1)]);
		end else begin
			w.op = 2'($urandom);
		end
		return track_ram(w);
	endfunction

	// Offer one word, idling first at random; return at the edge that takes it.
	task automatic send_word(input bscm_req_t w);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.note_access(w);
	endtask

	// Write all three registers on consecutive edges; the block must be idle.
	task automatic write_settings(input int prg, input int chr, input int fs);
		cfg_write_en <= 1'b1;
		cfg_index    <= CFG_PRG_BANKS;
		cfg_data     <= 9'(prg);
		@(posedge clk);
		sb.set_config(CFG_PRG_BANKS, 9'(prg));
		cfg_index <= CFG_CHR_SIZE;
		cfg_data  <= 9'(chr);
		@(posedge clk);
		sb.set_config(CFG_CHR_SIZE, 9'(chr));
		cfg_index <= CFG_FOUR_NT;
		cfg_data  <= 9'(fs);
		@(posedge clk);
		sb.set_config(CFG_FOUR_NT, 9'(fs));
		cfg_write_en <= 1'b0;
	endtask

	// Wait for every owed word, then let the two-stage pipe run dry.
	task automatic drain();
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		bscm_req_t opening [$];
		int        prg;
		int        chr;
		int        fs;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest sizes before any bank data: the fixed slots must reload.
		write_settings(2, 8, 1);

		// Directed opening: power-on slots at both ends of each window,
		// unmapped reads, RAM extremes, ignored writes, every register.
		opening.push_back(make_word(OP_PRG_READ,  16'h8000, 8'h00));
		opening.push_back(make_word(OP_PRG_READ,  16'hFFFF, 8'hFF));
		opening.push_back(make_word(OP_CHR_READ,  16'h0000, 8'h00));
		opening.push_back(make_word(OP_CHR_READ,  16'h1FFF, 8'h00));
		opening.push_back(make_word(OP_PRG_READ,  16'h0000, 8'h00));
		opening.push_back(make_word(OP_CHR_READ,  16'h3000, 8'h00));
		opening.push_back(make_word(OP_PRG_WRITE, 16'h6000, 8'hFF));
		opening.push_back(make_word(OP_PRG_WRITE, 16'h7FFF, 8'h00));
		opening.push_back(make_word(OP_PRG_READ,  16'h6000, 8'h00));
		opening.push_back(make_word(OP_PRG_READ,  16'h7FFF, 8'h00));
		opening.push_back(make_word(OP_CHR_WRITE, 16'h2000, 8'hA5));
		opening.push_back(make_word(OP_CHR_WRITE, 16'h2FFF, 8'h5A));
		opening.push_back(make_word(OP_CHR_WRITE, 16'h1FFF, 8'h12));
		opening.push_back(make_word(OP_CHR_WRITE, 16'h3000, 8'h34));
		opening.push_back(make_word(OP_CHR_READ,  16'h2FFF, 8'h00));
		opening.push_back(make_word(OP_PRG_WRITE, 16'hA000, 8'h01));
		opening.push_back(make_word(OP_PRG_WRITE, 16'hA001, 8'hFF));
		opening.push_back(make_word(OP_PRG_WRITE, 16'hC000, 8'hFF));
		opening.push_back(make_word(OP_PRG_WRITE, 16'hC001, 8'h00));
		opening.push_back(make_word(OP_PRG_WRITE, 16'hE001, 8'h00));
		opening.push_back(make_word(OP_PRG_WRITE, 16'h8000, 8'hC7));
		opening.push_back(make_word(OP_PRG_WRITE, 16'h8001, 8'hFF));
		opening.push_back(make_word(OP_PRG_READ,  16'h8000, 8'h00));
		opening.push_back(make_word(OP_CHR_READ,  16'h0000, 8'h00));
		opening.push_back(make_word(OP_PRG_WRITE, 16'hE000, 8'h00));
		foreach (opening[i])
			send_word(track_ram(opening[i]));
		req_valid <= 1'b0;

		// Random phases, each under its own register setting and idling pattern.
		for (int p = 0; p < PHASES; p++) begin
			drain();
			prg = phase_prg[p] < 0 ? $urandom_range(64, 2) : phase_prg[p];
			chr = phase_chr[p] < 0 ? $urandom_range(256, 8) : phase_chr[p];
			fs  = phase_fs[p] < 0 ? $urandom_range(1, 0) : phase_fs[p];
			write_settings(prg, chr, fs);
			tx_idle_pct  = phase_tx[p];
			rx_stall_pct <= phase_rx[p];
			repeat (PHASE_WORDS)
				send_word(next_access());
			req_valid <= 1'b0;
		end
		drain();

		$display("covered %0d accesses over %0d register settings", sb.checked, PHASES + 1);
		$display("PRG ROM %0d, CHR ROM %0d, PRG RAM %0d, nametable %0d, other %0d",
			sb.by_source[SRC_PRG_ROM], sb.by_source[SRC_CHR_ROM], sb.by_source[SRC_PRG_RAM],
			sb.by_source[SRC_NAMETABLE], sb.by_source[SRC_NONE]);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.errors, sb.outstanding());
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", sb.outstanding());
		$display("status: fail");
		$finish;
	end

endmodule
